// ===== design/run_length_block_splitter_macros.svh =====
// Assertion macros shared by the run-length block splitter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef RUN_LENGTH_BLOCK_SPLITTER_MACROS_SVH
`define RUN_LENGTH_BLOCK_SPLITTER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RLBS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define RLBS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rlbs_pkg.sv =====
// Package for the run-length block splitter: constants, codes, the job type
// passed from the front end to the back end, and the CRC and count helpers.
// Depends on nothing.
package rlbs_pkg;

    localparam int unsigned MAX_BLOCK_BYTES = 900000;
    localparam int unsigned LIMIT_MARGIN    = 19;
    localparam int unsigned LIMIT_CAP_I     = MAX_BLOCK_BYTES - LIMIT_MARGIN;
    localparam int unsigned LIMIT_RESET_I   = 899981;
    localparam int unsigned LIMIT_RESET_EFF_I =
        (LIMIT_RESET_I > LIMIT_CAP_I) ? LIMIT_CAP_I : LIMIT_RESET_I;

    localparam int FILL_W     = 20;
    localparam int CRC_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int RUNLEN_W   = 8;
    localparam int COUNT_W    = 3;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_PAD_W  = OUT_DATA_W - BYTE_W - CRC_W - FILL_W;

    localparam logic [FILL_W-1:0]   LIMIT_CAP       = FILL_W'(LIMIT_CAP_I);
    localparam logic [FILL_W-1:0]   LIMIT_RESET_EFF = FILL_W'(LIMIT_RESET_EFF_I);
    localparam logic [CRC_W-1:0]    CRC_POLY        = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0]    CRC_INIT        = 32'hFFFF_FFFF;
    localparam logic [RUNLEN_W-1:0] RUN_MAX         = 8'd255;
    localparam logic [RUNLEN_W-1:0] RUN_COPIES      = 8'd4;
    localparam logic [COUNT_W-1:0]  LONG_RUN_BYTES  = 3'd5;

    localparam int DEFAULT_QUEUE_DEPTH = 4;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // One queued job: an optional block end before the run bytes, the run
    // bytes, and an optional block end after them.
    typedef struct packed {
        logic                    close_first;
        logic                    close_last;
        logic [CRC_W-1:0]        end_crc;
        logic [FILL_W-1:0]       end_len;
        logic [BYTE_W-1:0]       run_chr;
        logic [RUNLEN_W-1:0]     run_len;
    } t_job;

    // One byte of CRC-32, MSB first.
    function automatic logic [CRC_W-1:0] f_crc_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 24'h0};
        for (int i = 0; i < 8; i++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // Encoded bytes produced by a run: one to three pass through, longer runs
    // become four copies and a count byte.
    function automatic logic [COUNT_W-1:0] f_emit_count(input logic [RUNLEN_W-1:0] n);
        logic [COUNT_W-1:0] r;
        if (n >= RUN_COPIES) begin
            r = LONG_RUN_BYTES;
        end else begin
            r = COUNT_W'(n);
        end
        return r;
    endfunction

endpackage

// ===== design/rlbs_front.sv =====
// Front end of the run-length block splitter: run tracking, block fill,
// block CRC and the limit register; turns each word into at most one queued job.
// Depends on rlbs_pkg.
module rlbs_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rlbs_pkg::FILL_W-1:0]   i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_command,
    input  logic [rlbs_pkg::BYTE_W-1:0]   i_byte,
    input  logic                          i_q_ready,
    output logic                          o_push,
    output rlbs_pkg::t_job                o_job
);
    import rlbs_pkg::*;

    logic [FILL_W-1:0]   r_limit;
    logic                r_open;
    logic [FILL_W-1:0]   r_fill,    n_fill;
    logic                r_run_vld, n_run_vld;
    logic [BYTE_W-1:0]   r_run_chr, n_run_chr;
    logic [RUNLEN_W-1:0] r_run_len, n_run_len;
    // r_crc is the committed block CRC, r_proj the same advanced over the
    // pending run, r_alt an all-ones start advanced over the pending run.
    logic [CRC_W-1:0]    r_crc,  n_crc;
    logic [CRC_W-1:0]    r_proj, n_proj;
    logic [CRC_W-1:0]    r_alt,  n_alt;
    logic                n_open;

    logic                accept;
    logic                lim_reached;
    logic                closing;
    logic [CRC_W-1:0]    b_crc, b_proj;
    logic [FILL_W-1:0]   b_fill;
    logic                extend;
    logic [RUNLEN_W-1:0] emit_len;
    logic [FILL_W-1:0]   fill_after;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    assign lim_reached = r_fill >= r_limit;
    assign closing     = !r_open || lim_reached;
    assign b_crc       = closing ? CRC_INIT : r_crc;
    // A run left pending across a block close is counted in the new block.
    assign b_proj      = closing ? r_alt : r_proj;
    assign b_fill      = closing ? '0 : r_fill;
    assign extend      = r_run_vld && (i_byte == r_run_chr) && (r_run_len != RUN_MAX);

    always_comb begin
        n_open    = r_open;
        n_fill    = r_fill;
        n_run_vld = r_run_vld;
        n_run_chr = r_run_chr;
        n_run_len = r_run_len;
        n_crc     = r_crc;
        n_proj    = r_proj;
        n_alt     = r_alt;
        emit_len  = '0;
        fill_after = '0;
        o_job     = '0;
        o_push    = 1'b0;
        if (i_command == CMD_DATA) begin
            emit_len  = extend ? '0 : r_run_len;
            fill_after = b_fill + FILL_W'(f_emit_count(emit_len));
            n_open    = 1'b1;
            n_fill    = fill_after;
            n_run_vld = 1'b1;
            n_run_chr = i_byte;
            n_run_len = extend ? (r_run_len + 8'd1) : 8'd1;
            n_crc     = extend ? b_crc : b_proj;
            n_proj    = f_crc_byte(b_proj, i_byte);
            n_alt     = f_crc_byte(extend ? r_alt : CRC_INIT, i_byte);
            o_job.close_first = r_open && lim_reached;
            o_job.close_last  = 1'b0;
            o_job.end_crc     = ~r_crc;
            o_job.end_len     = r_fill;
            o_job.run_chr     = r_run_chr;
            o_job.run_len     = emit_len;
            o_push = accept && (o_job.close_first || (emit_len != '0));
        end else begin
            emit_len   = r_run_len;
            fill_after = r_fill + FILL_W'(f_emit_count(emit_len));
            n_open    = 1'b0;
            n_fill    = '0;
            n_run_vld = 1'b0;
            n_run_chr = '0;
            n_run_len = '0;
            n_crc     = CRC_INIT;
            n_proj    = CRC_INIT;
            n_alt     = CRC_INIT;
            o_job.close_first = 1'b0;
            // An empty or unopened block gives no block end on flush.
            o_job.close_last  = r_open && (fill_after != '0);
            o_job.end_crc     = ~r_proj;
            o_job.end_len     = fill_after;
            o_job.run_chr     = r_run_chr;
            o_job.run_len     = emit_len;
            o_push = accept && (o_job.close_last || (emit_len != '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET_EFF;
            r_open    <= 1'b0;
            r_fill    <= '0;
            r_run_vld <= 1'b0;
            r_run_chr <= '0;
            r_run_len <= '0;
            r_crc     <= CRC_INIT;
            r_proj    <= CRC_INIT;
            r_alt     <= CRC_INIT;
        end else begin
            if (i_cfg_we) begin
                r_limit <= (i_cfg_wdata > LIMIT_CAP) ? LIMIT_CAP : i_cfg_wdata;
            end
            if (accept) begin
                r_open    <= n_open;
                r_fill    <= n_fill;
                r_run_vld <= n_run_vld;
                r_run_chr <= n_run_chr;
                r_run_len <= n_run_len;
                r_crc     <= n_crc;
                r_proj    <= n_proj;
                r_alt     <= n_alt;
            end
        end
    end

endmodule

// ===== design/rlbs_queue.sv =====
// Job queue between the front end and the back end of the block splitter.
// Depends on rlbs_pkg.
module rlbs_queue #(
    parameter int DEPTH = rlbs_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rlbs_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_valid,
    output rlbs_pkg::t_job o_job,
    input  logic           i_pop
);
    import rlbs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_ready = r_cnt != CNT_FULL;
    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : (r_wr + 1'b1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : (r_rd + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== design/rlbs_back.sv =====
// Back end of the block splitter: expands the job at the queue head into
// result words, one a cycle while the output is not stalled, through an output register.
// Depends on rlbs_pkg and run_length_block_splitter_macros.svh.
`include "run_length_block_splitter_macros.svh"

module rlbs_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  rlbs_pkg::t_job                    i_job,
    output logic                              o_pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rlbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);
    import rlbs_pkg::*;

    logic                  r_out_valid;
    logic [COUNT_W-1:0]    r_step, n_step;
    logic [BYTE_W-1:0]     r_byte, n_byte;
    logic [CRC_W-1:0]      r_crc,  n_crc;
    logic [FILL_W-1:0]     r_len,  n_len;
    logic                  r_kind, n_kind;
    logic                  r_last;

    logic [COUNT_W-1:0]    cnt;
    logic [COUNT_W-1:0]    total;
    logic [COUNT_W-1:0]    idx;
    logic                  is_close;
    logic                  is_last;
    logic                  load;

    assign cnt   = f_emit_count(i_job.run_len);
    assign total = cnt + COUNT_W'(i_job.close_first) + COUNT_W'(i_job.close_last);
    assign idx   = r_step - COUNT_W'(i_job.close_first);
    // Position zero of a job with a leading block end is that block end.
    assign is_close = (i_job.close_first && (r_step == '0)) || (idx >= cnt);
    assign is_last  = r_step == (total - 1'b1);
    assign load     = i_q_valid && (!r_out_valid || m_axis_tready);
    assign o_pop    = load && is_last;

    always_comb begin
        n_step = is_last ? '0 : (r_step + 1'b1);
        if (is_close) begin
            n_kind = KIND_END;
            n_byte = '0;
            n_crc  = i_job.end_crc;
            n_len  = i_job.end_len;
        end else begin
            n_kind = KIND_BYTE;
            // The fifth byte of a long run is its count.
            n_byte = (idx == COUNT_W'(RUN_COPIES)) ? (i_job.run_len - RUN_COPIES)
                                                   : i_job.run_chr;
            n_crc  = '0;
            n_len  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_out_valid <= load || (r_out_valid && !m_axis_tready);
            if (load) begin
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_crc  <= n_crc;
            r_len  <= n_len;
            r_last <= is_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_len, r_crc, r_byte};
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;

    `RLBS_ASSERT(a_idle_step, i_clk, i_rst_n, !i_q_valid |-> (r_step == '0), "idle step")
    `RLBS_ASSERT(a_step_range, i_clk, i_rst_n, i_q_valid |-> (r_step < total), "step overrun")
    `RLBS_ASSERT(a_job_nonempty, i_clk, i_rst_n, i_q_valid |-> (total != '0), "empty job")
    `RLBS_ASSERT_NEXT(a_pop_restarts, i_clk, i_rst_n, o_pop, r_step == '0, "step not rewound")

endmodule

// ===== design/run_length_block_splitter.sv =====
// Top level of the run-length block splitter: front end, job queue, back end.
// Depends on rlbs_pkg, rlbs_front, rlbs_queue and rlbs_back.
//
//  channel   | direction | handshake            | payload (low bit first)
//  ----------+-----------+----------------------+----------------------------------
//  s_axis    | in        | tvalid/tready        | tuser: command; tdata: in_byte
//  m_axis    | out       | tvalid/tready, tlast | tuser: kind; tdata: out_byte,
//            |           |                      |   block_crc, block_length, 4 zeros
//  cfg       | in        | i_cfg_we             | i_cfg_wdata: block_limit
//
// The front end takes one word per cycle while the queue has room and updates
// run, fill and CRC in that cycle; each word becomes at most one job in the queue.
// The back end sends one result per cycle while m_axis_tready is high; up to
// six results come from one word.
// The queue (QUEUE_DEPTH jobs) lets the front keep accepting while the back
// is stalled or expanding a long job; s_axis_tready drops when it is full.
// Reset is synchronous; after it block_limit is 899981 and no block is open.
module run_length_block_splitter #(
    parameter int QUEUE_DEPTH = rlbs_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rlbs_pkg::FILL_W-1:0]       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rlbs_pkg::BYTE_W-1:0]       s_axis_tdata,  // in_byte
    input  logic                              s_axis_tuser,  // command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_byte [7:0], block_crc [39:8], block_length [59:40], zeros [63:60]
    output logic [rlbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser,  // kind
    output logic                              m_axis_tlast
);
    import rlbs_pkg::*;

    logic q_ready;
    logic q_valid;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    rlbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_command   (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_job       (push_job)
    );

    rlbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (pop)
    );

    rlbs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (head_job),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
